[sv/cacf_pkg.sv]
// Shared types and constants for the cell-averaging CFAR I/Q detector.
// Holds the transaction payload structs, register codes and default sizes.
// No dependencies.
package cacf_pkg;

  // Default sizes, handed to the top level as parameter defaults
  localparam int unsigned TRAIN_DEF       = 32;
  localparam int unsigned GUARD_DEF       = 2;
  localparam int unsigned WINDOW_DEF      = 69;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  // Fixed field widths
  localparam int unsigned FIELD_W = 16;
  localparam int unsigned POWER_W = 32;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned FRAC_W  = 4;

  // Width of one training-side sum at the default sizes
  localparam int unsigned SIDE_W_DEF = POWER_W + $clog2(TRAIN_DEF + 1);

  // Register reset values
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd768;
  localparam logic [FRAC_W-1:0] FRAC_RESET = 4'd8;

  // Register port geometry and register select codes
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned REG_SEL_BIT = 2;
  localparam logic        REG_GAIN    = 1'b0;
  localparam logic        REG_FRAC    = 1'b1;

  typedef struct packed {
    logic signed [FIELD_W-1:0] in_real;
    logic signed [FIELD_W-1:0] in_imag;
  } in_item_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] out_real;
    logic signed [FIELD_W-1:0] out_imag;
    logic                      detected;
  } out_item_t;

  // Threshold settings from the register block
  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic [FRAC_W-1:0] frac;
  } cfg_t;

endpackage

[sv/cacf_regs.sv]
// Register block of the CFAR detector: threshold gain and fraction bits.
// APB-style write/read port, zero wait states. Depends on cacf_pkg.
module cacf_regs import cacf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [GAIN_W-1:0] gain_r;
  logic [FRAC_W-1:0] frac_r;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  // Write on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
      frac_r <= FRAC_RESET;
    end else if (wr_en) begin
      unique case (paddr[REG_SEL_BIT])
        REG_GAIN: gain_r <= pwdata[GAIN_W-1:0];
        REG_FRAC: frac_r <= pwdata[FRAC_W-1:0];
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (paddr[REG_SEL_BIT])
      REG_GAIN: prdata = APB_DATA_W'(gain_r);
      REG_FRAC: prdata = APB_DATA_W'(frac_r);
    endcase
  end

  assign cfg.gain = gain_r;
  assign cfg.frac = frac_r;

endmodule

[sv/cacf_mem.sv]
// Circular power window store: one write port, two read ports, read data
// registered. Depends on cacf_pkg.
module cacf_mem import cacf_pkg::*; #(
  parameter  int unsigned DEPTH  = WINDOW_DEF,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [ADDR_W-1:0]  waddr,
  input  logic [POWER_W-1:0] wdata,
  input  logic [ADDR_W-1:0]  raddr0,
  input  logic [ADDR_W-1:0]  raddr1,
  output logic [POWER_W-1:0] rdata0,
  output logic [POWER_W-1:0] rdata1
);

  logic [POWER_W-1:0] mem_q [DEPTH];

  // Write and read, contents not cleared (the fill count masks stale entries)
  always_ff @(posedge clk) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata0 <= mem_q[raddr0];
    rdata1 <= mem_q[raddr1];
  end

endmodule

[sv/cacf_thresh.sv]
// Threshold and decision stages: average the training sums, scale by the
// gain, compare with the centre cell and drive the output register.
// Depends on cacf_pkg.
module cacf_thresh import cacf_pkg::*; #(
  parameter int unsigned TRAIN_PER_SIDE = TRAIN_DEF,
  parameter int unsigned SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int unsigned SIDE_W         = SIDE_W_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               go,
  input  logic [SIDE_W-1:0]  side_l,
  input  logic [SIDE_W-1:0]  side_r,
  input  logic [POWER_W-1:0] centre,
  input  in_item_t           sample,
  output logic               done,
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_data
);

  localparam int unsigned SUM_W     = SIDE_W + 1;
  localparam int unsigned AVG_SHIFT = $clog2(2 * TRAIN_PER_SIDE + 1) - 1;
  localparam int unsigned AVG_W     = SUM_W - AVG_SHIFT;
  localparam int unsigned PROD_W    = AVG_W + GAIN_W;
  localparam logic [FIELD_W-1:0] SMASK = FIELD_W'((64'd1 << SAMPLE_BITS) - 64'd1);

  logic [SUM_W-1:0]   sum_w;
  logic [AVG_W-1:0]   avg_nxt;
  logic [AVG_W-1:0]   avg_r;
  logic [PROD_W-1:0]  prod_r;
  logic [PROD_W-1:0]  thr_w;
  logic [POWER_W-1:0] ctr_r;
  in_item_t           smp_r;
  logic               v1_r;
  logic               v2_r;
  logic               det_w;
  logic               out_free;
  logic               load_out;
  logic               out_valid_r;
  out_item_t          out_data_r;

  // Average of both training sides
  assign sum_w   = SUM_W'(side_l) + SUM_W'(side_r);
  assign avg_nxt = AVG_W'(sum_w >> AVG_SHIFT);

  // Scaled threshold and decision
  assign thr_w = prod_r >> cfg.frac;
  assign det_w = PROD_W'(ctr_r) > thr_w;

  assign out_free = !out_valid_r || !out_stall;
  assign load_out = v2_r && out_free;
  assign done     = load_out;

  // Stage valids and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r <= go;
      if (v1_r) begin
        v2_r <= 1'b1;
      end else if (load_out) begin
        v2_r <= 1'b0;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (go) begin
      avg_r <= avg_nxt;
      ctr_r <= centre;
      smp_r <= sample;
    end
    if (v1_r) begin
      prod_r <= PROD_W'(avg_r) * PROD_W'(cfg.gain);
    end
    if (load_out) begin
      out_data_r.out_real <= det_w ? (smp_r.in_real & SMASK) : '0;
      out_data_r.out_imag <= det_w ? (smp_r.in_imag & SMASK) : '0;
      out_data_r.detected <= det_w;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A new item only enters an empty pipeline
  a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
    go |-> !v1_r && !v2_r)
    else $error("threshold pipeline started while busy");

  // No detection means both samples are zero
  a_zero_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.detected |->
      out_data_r.out_real == '0 && out_data_r.out_imag == '0)
    else $error("sample passed without detection");

  // A finished decision waits while the output register is full
  a_hold_dec: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && !load_out |=> v2_r)
    else $error("decision lost under stall");

endmodule

[sv/ca_cfar_iq_detector.sv]
// Cell-averaging CFAR detector on an I/Q stream, top level and sequencer.
// Uses cacf_pkg, cacf_regs, cacf_mem and cacf_thresh.
//
//   channel  direction  handshake                payload
//   in_      into block in_valid / in_stall      in_data  (in_item_t)
//   out_     from block out_valid / out_stall    out_data (out_item_t)
//   APB      into block psel/penable/pwrite      paddr, pwdata -> prdata
//
// Each item passes two read passes over the two-port window memory, a
// write-back, then the average, multiply and compare stages; the next item
// is accepted only once the last one is loaded into the output register.
// Running sums of both training sides are updated from the cells entering
// and leaving each side. Reset is synchronous (rst_n low); no clearing pass,
// a fill count masks window entries not yet written. out_stall holds the
// result in the output register; one next transaction is still accepted meanwhile.
module ca_cfar_iq_detector import cacf_pkg::*; #(
  parameter int unsigned TRAIN_PER_SIDE = TRAIN_DEF,
  parameter int unsigned GUARD_PER_SIDE = GUARD_DEF,
  parameter int unsigned WINDOW_LENGTH  = WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS    = SAMPLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned SIDE_CELLS =
    (TRAIN_PER_SIDE < WINDOW_LENGTH) ? TRAIN_PER_SIDE : WINDOW_LENGTH;
  localparam int unsigned CENTRE_IDX = TRAIN_PER_SIDE + GUARD_PER_SIDE;
  localparam int unsigned PTR_W      = $clog2(WINDOW_LENGTH);
  localparam int unsigned FILL_W     = $clog2(WINDOW_LENGTH + 1);
  localparam int unsigned SIDE_W     = POWER_W + $clog2(SIDE_CELLS + 1);

  // Special window shapes: left side reaching the newest cell, centre
  // outside the window, centre on the newest cell
  localparam bit ENTER_NEW  = (SIDE_CELLS == WINDOW_LENGTH);
  localparam bit CENTRE_OUT = (CENTRE_IDX >= WINDOW_LENGTH);
  localparam bit CENTRE_NEW = (CENTRE_IDX + 1 == WINDOW_LENGTH);

  // Ages of the cells read before the write (age 0 = newest stored)
  localparam int unsigned AGE_OLD = WINDOW_LENGTH - 1;
  localparam int unsigned AGE_RX  = SIDE_CELLS - 1;
  localparam int unsigned AGE_LIN = ENTER_NEW ? 0 : WINDOW_LENGTH - SIDE_CELLS - 1;
  localparam int unsigned AGE_CTR =
    (CENTRE_IDX + 2 <= WINDOW_LENGTH) ? WINDOW_LENGTH - 2 - CENTRE_IDX : 0;

  localparam logic [PTR_W:0] WIN_SZ  = (PTR_W+1)'(WINDOW_LENGTH);
  localparam logic [PTR_W:0] OFF_OLD = (PTR_W+1)'(WINDOW_LENGTH - 1 - AGE_OLD);
  localparam logic [PTR_W:0] OFF_RX  = (PTR_W+1)'(WINDOW_LENGTH - 1 - AGE_RX);
  localparam logic [PTR_W:0] OFF_LIN = (PTR_W+1)'(WINDOW_LENGTH - 1 - AGE_LIN);
  localparam logic [PTR_W:0] OFF_CTR = (PTR_W+1)'(WINDOW_LENGTH - 1 - AGE_CTR);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD2  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;
  localparam logic [1:0] ST_WAIT = 2'd3;

  cfg_t                     cfg;
  logic [1:0]               state_r;
  logic [1:0]               state_nxt;
  logic [PTR_W-1:0]         wp_r;
  logic [PTR_W-1:0]         wp_nxt;
  logic [FILL_W-1:0]        fill_r;
  logic [FILL_W-1:0]        fill_nxt;
  logic [SIDE_W-1:0]        l_r;
  logic [SIDE_W-1:0]        r_r;
  logic [SIDE_W-1:0]        l_nxt;
  logic [SIDE_W-1:0]        r_nxt;
  logic [SIDE_W-1:0]        lp_r;
  logic [SIDE_W-1:0]        rp_r;
  logic [SIDE_W-1:0]        lp_nxt;
  logic [SIDE_W-1:0]        rp_nxt;
  logic [POWER_W-1:0]       power_in;
  logic [POWER_W-1:0]       power_r;
  logic [POWER_W-1:0]       enter_pw;
  logic [POWER_W-1:0]       centre_nxt;
  logic [POWER_W-1:0]       centre_r;
  in_item_t                 smp_r;
  logic signed [SAMPLE_BITS-1:0]   re_s;
  logic signed [SAMPLE_BITS-1:0]   im_s;
  logic signed [2*SAMPLE_BITS-1:0] re_sq;
  logic signed [2*SAMPLE_BITS-1:0] im_sq;
  logic [PTR_W:0]           off0;
  logic [PTR_W:0]           off1;
  logic [FILL_W-1:0]        age0;
  logic [FILL_W-1:0]        age1;
  logic [PTR_W-1:0]         raddr0;
  logic [PTR_W-1:0]         raddr1;
  logic [POWER_W-1:0]       rdata0;
  logic [POWER_W-1:0]       rdata1;
  logic                     vld0_r;
  logic                     vld1_r;
  logic                     accept;
  logic                     mem_we;
  logic                     go_r;
  logic                     thr_done;

  // Slot of a stored cell: write pointer minus one minus its age, wrapped
  function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] base,
                                               input logic [PTR_W:0]   off);
    logic [PTR_W:0] s;
    s = {1'b0, base} + off;
    if (s >= WIN_SZ) begin
      s = s - WIN_SZ;
    end
    return s[PTR_W-1:0];
  endfunction

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign mem_we   = (state_r == ST_UPD);

  // Power of the incoming sample, wrapping at 32 bits
  assign re_s     = in_data.in_real[SAMPLE_BITS-1:0];
  assign im_s     = in_data.in_imag[SAMPLE_BITS-1:0];
  assign re_sq    = re_s * re_s;
  assign im_sq    = im_s * im_s;
  assign power_in = POWER_W'(unsigned'(re_sq)) + POWER_W'(unsigned'(im_sq));

  // Read addresses: leaving cells first, then entering and centre cells
  always_comb begin
    if (state_r == ST_RD2) begin
      off0 = OFF_LIN;
      off1 = OFF_CTR;
      age0 = FILL_W'(AGE_LIN);
      age1 = FILL_W'(AGE_CTR);
    end else begin
      off0 = OFF_OLD;
      off1 = OFF_RX;
      age0 = FILL_W'(AGE_OLD);
      age1 = FILL_W'(AGE_RX);
    end
  end

  assign raddr0 = slot_of(wp_r, off0);
  assign raddr1 = slot_of(wp_r, off1);

  // Side sums: drop the leaving cells, then add the entering ones
  assign lp_nxt   = l_r - (vld0_r ? SIDE_W'(rdata0) : '0);
  assign rp_nxt   = r_r - (vld1_r ? SIDE_W'(rdata1) : '0);
  assign enter_pw = ENTER_NEW ? power_r : (vld0_r ? rdata0 : '0);
  assign l_nxt    = lp_r + SIDE_W'(enter_pw);
  assign r_nxt    = rp_r + SIDE_W'(power_r);

  always_comb begin
    if (CENTRE_OUT) begin
      centre_nxt = '0;
    end else if (CENTRE_NEW) begin
      centre_nxt = power_r;
    end else begin
      centre_nxt = vld1_r ? rdata1 : '0;
    end
  end

  // Advance write pointer and fill count
  assign wp_nxt   = (wp_r == PTR_W'(WINDOW_LENGTH - 1)) ? '0 : wp_r + 1'b1;
  assign fill_nxt = (fill_r == FILL_W'(WINDOW_LENGTH)) ? fill_r : fill_r + 1'b1;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_RD2;
      ST_RD2:  state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_WAIT;
      ST_WAIT: if (thr_done) state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wp_r    <= '0;
      fill_r  <= '0;
      l_r     <= '0;
      r_r     <= '0;
      go_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      go_r    <= (state_r == ST_UPD);
      if (state_r == ST_UPD) begin
        wp_r   <= wp_nxt;
        fill_r <= fill_nxt;
        l_r    <= l_nxt;
        r_r    <= r_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    vld0_r <= (fill_r > age0);
    vld1_r <= (fill_r > age1);
    if (accept) begin
      power_r <= power_in;
      smp_r   <= in_data;
    end
    if (state_r == ST_RD2) begin
      lp_r <= lp_nxt;
      rp_r <= rp_nxt;
    end
    if (state_r == ST_UPD) begin
      centre_r <= centre_nxt;
    end
  end

  cacf_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cacf_mem #(
    .DEPTH (WINDOW_LENGTH)
  ) u_mem (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (wp_r),
    .wdata  (power_r),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

  cacf_thresh #(
    .TRAIN_PER_SIDE (TRAIN_PER_SIDE),
    .SAMPLE_BITS    (SAMPLE_BITS),
    .SIDE_W         (SIDE_W)
  ) u_thresh (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .go        (go_r),
    .side_l    (l_r),
    .side_r    (r_r),
    .centre    (centre_r),
    .sample    (smp_r),
    .done      (thr_done),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Write-back follows an accepted transaction after the second read pass
  a_upd_timing: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_UPD |-> $past(in_valid && !in_stall, 2))
    else $error("window update without accepted transaction");

  // Fill count moves only with a window write
  a_fill_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !mem_we |=> $stable(fill_r))
    else $error("fill count changed without a write");

  // Empty window has empty side sums
  a_empty_sums: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r == '0 |-> l_r == '0 && r_r == '0)
    else $error("side sums non-zero on empty window");

endmodule
